@@ hdl/bzf_pkg.sv @@
// shared types, constants and weight function for the cubic bezier flattener
`timescale 1ns / 1ps

package bzf_pkg;

    localparam int COORD_W    = 24;
    localparam int SUBDIV_DEF = 16;
    localparam int LANES      = 2;
    localparam int CTRL_PTS   = 4;
    // quotient bits of the rounding divider, offset result included
    localparam int QUOT_W     = COORD_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } bzf_tag_t;

    // bernstein weight of control point j at u = k/n, scaled by n^3
    function automatic int bzf_weight(input int n, input int k, input int j);
        int t;
        int w;
        t = n - k;
        case (j)
            0:       w = t * t * t;
            1:       w = 3 * k * t * t;
            2:       w = 3 * k * k * t;
            default: w = k * k * k;
        endcase
        return w;
    endfunction

endpackage

@@ hdl/bzf_seq.sv @@
// segment hold registers and step sequencer that issues one curve point per cycle while advance is high
`timescale 1ns / 1ps

module bzf_seq
    import bzf_pkg::*;
#(
    parameter int SUBDIV = SUBDIV_DEF,
    parameter int WW     = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic          s_valid,
    output logic          s_ready,
    input  coord_t        s_start_x,
    input  coord_t        s_start_y,
    input  coord_t        s_ctrl1_x,
    input  coord_t        s_ctrl1_y,
    input  coord_t        s_ctrl2_x,
    input  coord_t        s_ctrl2_y,
    input  coord_t        s_end_x,
    input  coord_t        s_end_y,
    output bzf_tag_t      issue,
    output coord_t        hold_x [CTRL_PTS],
    output coord_t        hold_y [CTRL_PTS],
    output logic [WW-1:0] weight [CTRL_PTS]
);

    localparam int KW = (SUBDIV > 1) ? $clog2(SUBDIV) : 1;

    logic          busy_reg, busy_next;
    logic [KW-1:0] step_reg, step_next;
    logic          straight_reg, straight_next;
    logic [WW-1:0] w_reg [CTRL_PTS];
    logic [WW-1:0] w_next [CTRL_PTS];
    coord_t        hx_reg [CTRL_PTS];
    coord_t        hy_reg [CTRL_PTS];
    logic          issue_last;
    logic          accept;

    assign issue_last = straight_reg || (step_reg == KW'(SUBDIV - 1));
    assign s_ready    = advance && (!busy_reg || issue_last);
    assign accept     = s_valid && s_ready;

    assign issue.valid = busy_reg;
    assign issue.first = (step_reg == '0);
    assign issue.last  = issue_last;

    always_comb begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        straight_next = straight_reg;
        if (advance && busy_reg) begin
            if (issue_last) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
        if (accept) begin
            busy_next     = 1'b1;
            step_next     = '0;
            straight_next = (s_ctrl1_x == s_start_x) && (s_ctrl1_y == s_start_y) &&
                            (s_ctrl2_x == s_end_x) && (s_ctrl2_y == s_end_y);
        end
    end

    // weights for the step that will be issued next
    always_comb begin
        for (int j = 0; j < CTRL_PTS; j++) begin
            w_next[j] = w_reg[j];
        end
        for (int k = 0; k < SUBDIV; k++) begin
            if (step_next == KW'(k)) begin
                for (int j = 0; j < CTRL_PTS; j++) begin
                    w_next[j] = WW'(bzf_weight(SUBDIV, k, j));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            straight_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            straight_reg <= straight_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < CTRL_PTS; j++) begin
            w_reg[j] <= w_next[j];
        end
        if (accept) begin
            hx_reg[0] <= s_start_x;
            hy_reg[0] <= s_start_y;
            hx_reg[1] <= s_ctrl1_x;
            hy_reg[1] <= s_ctrl1_y;
            hx_reg[2] <= s_ctrl2_x;
            hy_reg[2] <= s_ctrl2_y;
            hx_reg[3] <= s_end_x;
            hy_reg[3] <= s_end_y;
        end
    end

    assign hold_x = hx_reg;
    assign hold_y = hy_reg;
    assign weight = w_reg;

endmodule

@@ hdl/bzf_mac.sv @@
// weighted sum of the four control points, three register stages, biased dividend out
`timescale 1ns / 1ps

module bzf_mac
    import bzf_pkg::*;
#(
    parameter int WW  = 13,
    parameter int XW  = 39,
    parameter int DEN = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  bzf_tag_t      tag_in,
    input  coord_t        hold_x [CTRL_PTS],
    input  coord_t        hold_y [CTRL_PTS],
    input  logic [WW-1:0] weight [CTRL_PTS],
    output bzf_tag_t      tag_out,
    output logic [XW-1:0] dvd_out [LANES]
);

    localparam int PW = COORD_W + WW + 1;
    localparam int NW = PW + 1;
    localparam logic signed [XW:0] BIAS =
        (XW + 1)'(DEN) + ((XW + 1)'(DEN) << (COORD_W + 1));

    bzf_tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic signed [PW-1:0]  prod_next [LANES][CTRL_PTS];
    logic signed [PW-1:0]  prod_reg  [LANES][CTRL_PTS];
    logic signed [NW-1:0]  pa_reg [LANES];
    logic signed [NW-1:0]  pb_reg [LANES];
    logic signed [XW:0]    dvd_next [LANES];
    logic [XW-1:0]         dvd_reg [LANES];

    always_comb begin
        for (int j = 0; j < CTRL_PTS; j++) begin
            prod_next[0][j] = PW'(hold_x[j]) * PW'($signed({1'b0, weight[j]}));
            prod_next[1][j] = PW'(hold_y[j]) * PW'($signed({1'b0, weight[j]}));
        end
    end

    // 2*num + den, plus an offset that keeps the dividend positive
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            dvd_next[l] = (((XW + 1)'(pa_reg[l]) + (XW + 1)'(pb_reg[l])) <<< 1) + BIAS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else if (advance) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            for (int l = 0; l < LANES; l++) begin
                pa_reg[l]  <= NW'(prod_reg[l][0]) + NW'(prod_reg[l][1]);
                pb_reg[l]  <= NW'(prod_reg[l][2]) + NW'(prod_reg[l][3]);
                dvd_reg[l] <= dvd_next[l][XW-1:0];
            end
        end
    end

    assign tag_out = tag3_reg;
    assign dvd_out = dvd_reg;

endmodule

@@ hdl/bzf_div.sv @@
// division of the biased dividend by the constant 2*n^3 through a scaled reciprocal, clamp and output register
`timescale 1ns / 1ps

module bzf_div
    import bzf_pkg::*;
#(
    parameter int XW  = 39,
    parameter int DEN = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  bzf_tag_t      tag_in,
    input  logic [XW-1:0] dvd_in [LANES],
    output logic          out_valid,
    output coord_t        point_x,
    output coord_t        point_y,
    output logic          is_corner,
    output logic          last_point
);

    localparam int     QB      = QUOT_W;
    localparam longint DIVISOR = 2 * longint'(DEN);
    localparam int     DL      = $clog2(DIVISOR);
    // dividend bits below LO_SH are left out of the estimate
    localparam int     LO_SH   = (DL > 2) ? DL - 2 : 0;
    localparam int     SCALE   = DL + QB + 1;
    localparam int     HW      = QB + 2;
    localparam int     MW      = 2 * HW;
    localparam int     Q_SH    = SCALE - LO_SH;
    localparam logic [HW-1:0] RECIP = HW'((longint'(1) <<< SCALE) / DIVISOR);
    localparam logic [XW-1:0] DSOR  = XW'(DIVISOR);
    localparam logic signed [QB:0] OFFSET = (QB + 1)'(2 ** COORD_W);
    localparam logic signed [QB:0] RMAX   = (QB + 1)'(2 ** (COORD_W - 1) - 1);
    localparam logic signed [QB:0] RMIN   = -(QB + 1)'(2 ** (COORD_W - 1));

    bzf_tag_t           tag_a_reg, tag_b_reg, tag_c_reg;
    logic [HW-1:0]      dvd_top [LANES];
    logic [MW-1:0]      prod_reg [LANES];
    logic [XW-1:0]      dvd_a_reg [LANES];
    logic [XW-1:0]      dvd_b_reg [LANES];
    logic [QB-1:0]      est [LANES];
    logic [QB-1:0]      est_reg [LANES];
    logic [XW-1:0]      back_reg [LANES];
    logic [XW-1:0]      rem [LANES];
    logic [QB-1:0]      quo_reg [LANES];
    logic signed [QB:0] res [LANES];
    coord_t             sat [LANES];
    logic               valid_reg;
    coord_t             px_reg, py_reg;
    logic               corner_reg, last_reg;

    // estimate is the quotient or one below it, the remainder check settles which
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            dvd_top[l] = HW'(dvd_in[l] >> LO_SH);
            est[l]     = QB'(prod_reg[l] >> Q_SH);
            rem[l]     = dvd_b_reg[l] - back_reg[l];
        end
    end

    // remove the dividend offset and clamp to the coordinate range
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            res[l] = $signed({1'b0, quo_reg[l]}) - OFFSET;
            if (res[l] > RMAX) begin
                sat[l] = RMAX[COORD_W-1:0];
            end else if (res[l] < RMIN) begin
                sat[l] = RMIN[COORD_W-1:0];
            end else begin
                sat[l] = res[l][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            valid_reg <= 1'b0;
        end else if (advance) begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            valid_reg <= tag_c_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int l = 0; l < LANES; l++) begin
                prod_reg[l]  <= MW'(dvd_top[l]) * MW'(RECIP);
                dvd_a_reg[l] <= dvd_in[l];
                est_reg[l]   <= est[l];
                back_reg[l]  <= XW'(est[l]) * DSOR;
                dvd_b_reg[l] <= dvd_a_reg[l];
                quo_reg[l]   <= est_reg[l] + QB'(rem[l] >= DSOR);
            end
            px_reg     <= sat[0];
            py_reg     <= sat[1];
            corner_reg <= tag_c_reg.first;
            last_reg   <= tag_c_reg.last;
        end
    end

    assign out_valid  = valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign is_corner  = corner_reg;
    assign last_point = last_reg;

endmodule

@@ hdl/cubic_bezier_flattener.sv @@
// top level of the cubic bezier flattener
`timescale 1ns / 1ps

// Each request on the s_ channel is one cubic Bezier segment (start, two control
// points, end, 24-bit signed fixed point). The block returns the curve points at
// u = k/SUBDIVISIONS for k = 0 .. SUBDIVISIONS-1 on the m_ channel, rounded to
// nearest with ties toward plus infinity; the first point has m_is_corner set and
// the final one m_last_point. A straight segment (control 1 equal to the start,
// control 2 equal to the end) gives only its start point, carrying both flags.
// Points leave at one per cycle unless m_ready holds them, paced by the step
// sequencer; the next segment is taken in the cycle its predecessor's last point
// is issued. Between issue and output lie 3 multiply-add stages, 3 divide stages
// and the output register. The whole pipeline holds while m_valid is high and
// m_ready low.
module cubic_bezier_flattener
    import bzf_pkg::*;
#(
    parameter int SUBDIVISIONS = SUBDIV_DEF
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_start_x,
    input  coord_t s_start_y,
    input  coord_t s_ctrl1_x,
    input  coord_t s_ctrl1_y,
    input  coord_t s_ctrl2_x,
    input  coord_t s_ctrl2_y,
    input  coord_t s_end_x,
    input  coord_t s_end_y,
    output logic   m_valid,
    input  logic   m_ready,
    output coord_t m_point_x,
    output coord_t m_point_y,
    output logic   m_is_corner,
    output logic   m_last_point
);

    localparam int DEN = SUBDIVISIONS ** 3;
    localparam int WW  = $clog2(DEN + 1);
    localparam int XW  = WW + COORD_W + 2;

    logic          advance;
    bzf_tag_t      issue;
    bzf_tag_t      mac_tag;
    coord_t        hold_x [CTRL_PTS];
    coord_t        hold_y [CTRL_PTS];
    logic [WW-1:0] weight [CTRL_PTS];
    logic [XW-1:0] dvd [LANES];

    assign advance = !m_valid || m_ready;

    bzf_seq #(
        .SUBDIV (SUBDIVISIONS),
        .WW     (WW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_start_x (s_start_x),
        .s_start_y (s_start_y),
        .s_ctrl1_x (s_ctrl1_x),
        .s_ctrl1_y (s_ctrl1_y),
        .s_ctrl2_x (s_ctrl2_x),
        .s_ctrl2_y (s_ctrl2_y),
        .s_end_x   (s_end_x),
        .s_end_y   (s_end_y),
        .issue     (issue),
        .hold_x    (hold_x),
        .hold_y    (hold_y),
        .weight    (weight)
    );

    bzf_mac #(
        .WW  (WW),
        .XW  (XW),
        .DEN (DEN)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .tag_in  (issue),
        .hold_x  (hold_x),
        .hold_y  (hold_y),
        .weight  (weight),
        .tag_out (mac_tag),
        .dvd_out (dvd)
    );

    bzf_div #(
        .XW  (XW),
        .DEN (DEN)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .tag_in     (mac_tag),
        .dvd_in     (dvd),
        .out_valid  (m_valid),
        .point_x    (m_point_x),
        .point_y    (m_point_y),
        .is_corner  (m_is_corner),
        .last_point (m_last_point)
    );

endmodule
